[rtl/dsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, codes and widths of the descriptor slot ring.
// ----------------------------------------------------------------------------
package dsr_pkg;

  // Field widths fixed by the port list
  localparam int OpW      = 2;
  localparam int SlotIdxW = 10;
  localparam int LenW     = 21;
  localparam int SeqW     = 16;
  localparam int TsW      = 32;
  localparam int StatW    = 3;
  localparam int CntW     = 64;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;

  localparam int RingOrderDefault = 10;
  localparam logic [LenW-1:0] MaxPayloadReset = LenW'(2048);

  // Operation codes
  localparam logic [OpW-1:0] OP_PUSH    = 2'd0;
  localparam logic [OpW-1:0] OP_POP     = 2'd1;
  localparam logic [OpW-1:0] OP_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RUNNING     = 1'b1;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 3'd0,
    STAT_STOPPED = 3'd1,
    STAT_BADARG  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_INUSE = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SeqW-1:0] seq;
    logic [TsW-1:0]  ts;
  } slot_payload_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write one free entry of the clearing pass
    logic accept;      // latch operation, read slot memories
    logic exec;        // decide, write back, update counters and result
  } dsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final entry
  } dsr_sts_t;

endpackage

[rtl/dsr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_ctrl
// Sequencer: clearing pass after reset, then accept / execute per operation.
// ----------------------------------------------------------------------------
module dsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dsr_pkg::dsr_sts_t sts_i,
  output dsr_pkg::dsr_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        busy_q;
  logic        done_q;

  always_comb begin
    cmd_o.clear_step = (state_q == S_CLEAR);
    cmd_o.accept     = (state_q == S_IDLE) && start_i;
    cmd_o.exec       = (state_q == S_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[rtl/dsr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_datapath
// Slot memories, ring heads, statistics counters, config and result registers.
// ----------------------------------------------------------------------------
module dsr_datapath #(
  parameter int SLOT_ORDER = dsr_pkg::RingOrderDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dsr_pkg::dsr_cmd_t                cmd_i,
  output dsr_pkg::dsr_sts_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic [dsr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dsr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [dsr_pkg::OpW-1:0]          operation_i,
  input  logic [dsr_pkg::SlotIdxW-1:0]     slot_index_i,
  input  logic [dsr_pkg::LenW-1:0]         length_in_i,
  input  logic [dsr_pkg::SeqW-1:0]         sequence_in_i,
  input  logic [dsr_pkg::TsW-1:0]          timestamp_in_i,
  output logic [dsr_pkg::StatW-1:0]        status_o,
  output logic [dsr_pkg::SlotIdxW-1:0]     slot_out_o,
  output logic [dsr_pkg::LenW-1:0]         length_out_o,
  output logic [dsr_pkg::SeqW-1:0]         sequence_out_o,
  output logic [dsr_pkg::TsW-1:0]          timestamp_out_o,
  output logic [dsr_pkg::CntW-1:0]         packets_pushed_o,
  output logic [dsr_pkg::CntW-1:0]         packets_popped_o,
  output logic [dsr_pkg::CntW-1:0]         bytes_pushed_o,
  output logic [dsr_pkg::CntW-1:0]         bytes_popped_o,
  output logic [dsr_pkg::CntW-1:0]         full_drops_o,
  output logic [dsr_pkg::CntW-1:0]         empty_pops_o
);

  localparam int SlotCount = 1 << SLOT_ORDER;
  localparam int WideW = (SLOT_ORDER > dsr_pkg::SlotIdxW) ? SLOT_ORDER : dsr_pkg::SlotIdxW;

  // Memories
  dsr_pkg::slot_state_e   state_mem [SlotCount];
  dsr_pkg::slot_payload_t payload_mem [SlotCount];

  // Configuration
  logic [dsr_pkg::LenW-1:0] max_payload_q;
  logic                     running_q;

  // Ring state
  logic [SLOT_ORDER-1:0] free_head_q;
  logic [SLOT_ORDER-1:0] ready_head_q;
  logic [SLOT_ORDER-1:0] clr_addr_q;

  // Latched operation and memory read data
  logic [dsr_pkg::OpW-1:0]      op_q;
  logic [dsr_pkg::SlotIdxW-1:0] idx_q;
  logic [dsr_pkg::LenW-1:0]     len_q;
  logic [dsr_pkg::SeqW-1:0]     seq_q;
  logic [dsr_pkg::TsW-1:0]      ts_q;
  dsr_pkg::slot_state_e         st_rd_q;
  dsr_pkg::slot_payload_t       pl_rd_q;

  // Counters
  logic [dsr_pkg::CntW-1:0] pkt_push_q, pkt_pop_q, byte_push_q, byte_pop_q;
  logic [dsr_pkg::CntW-1:0] full_q, empty_q;

  // Result registers
  dsr_pkg::status_e             status_q;
  logic [dsr_pkg::SlotIdxW-1:0] slot_out_q;
  dsr_pkg::slot_payload_t       pl_out_q;

  // Address selection for the read at accept
  logic [WideW-1:0]      idx_in_wide;
  logic [SLOT_ORDER-1:0] rd_addr;

  // Execute decisions
  logic [WideW-1:0]       idx_wide, free_wide, ready_wide;
  logic                   idx_out_of_range;
  dsr_pkg::status_e       status_d;
  logic                   push_ok, pop_ok, rel_ok, full_hit, empty_hit;
  logic [SLOT_ORDER-1:0]  rel_addr;
  dsr_pkg::slot_payload_t push_pl;

  assign sts_o.clear_last = &clr_addr_q;

  always_comb begin
    idx_in_wide = WideW'(slot_index_i);
    unique case (operation_i)
      dsr_pkg::OP_PUSH: rd_addr = free_head_q;
      dsr_pkg::OP_POP:  rd_addr = ready_head_q;
      default:          rd_addr = idx_in_wide[SLOT_ORDER-1:0];
    endcase
  end

  always_comb begin
    idx_wide         = WideW'(idx_q);
    free_wide        = WideW'(free_head_q);
    ready_wide       = WideW'(ready_head_q);
    idx_out_of_range = (idx_wide >> SLOT_ORDER) != '0;
    rel_addr         = idx_wide[SLOT_ORDER-1:0];
    push_pl.len      = len_q;
    push_pl.seq      = seq_q;
    push_pl.ts       = ts_q;

    status_d  = dsr_pkg::STAT_OK;
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    rel_ok    = 1'b0;
    full_hit  = 1'b0;
    empty_hit = 1'b0;

    if (!running_q) begin
      status_d = dsr_pkg::STAT_STOPPED;
    end else begin
      unique case (op_q)
        dsr_pkg::OP_PUSH: begin
          if (len_q > max_payload_q) begin
            status_d = dsr_pkg::STAT_BADARG;
          end else if (st_rd_q != dsr_pkg::SLOT_FREE) begin
            status_d = dsr_pkg::STAT_FULL;
            full_hit = 1'b1;
          end else if (idx_wide != free_wide) begin
            status_d = dsr_pkg::STAT_BADARG;
          end else begin
            push_ok = 1'b1;
          end
        end
        dsr_pkg::OP_POP: begin
          if (st_rd_q != dsr_pkg::SLOT_READY) begin
            status_d  = dsr_pkg::STAT_EMPTY;
            empty_hit = 1'b1;
          end else begin
            pop_ok = 1'b1;
          end
        end
        dsr_pkg::OP_RELEASE: begin
          if (idx_out_of_range || st_rd_q != dsr_pkg::SLOT_INUSE) begin
            status_d = dsr_pkg::STAT_BADARG;
          end else begin
            rel_ok = 1'b1;
          end
        end
        default: status_d = dsr_pkg::STAT_BADARG;
      endcase
    end
  end

  // Slot state memory: clearing pass, then execute write-back; read at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      state_mem[clr_addr_q] <= dsr_pkg::SLOT_FREE;
    end else if (cmd_i.exec && push_ok) begin
      state_mem[free_head_q] <= dsr_pkg::SLOT_READY;
    end else if (cmd_i.exec && pop_ok) begin
      state_mem[ready_head_q] <= dsr_pkg::SLOT_INUSE;
    end else if (cmd_i.exec && rel_ok) begin
      state_mem[rel_addr] <= dsr_pkg::SLOT_FREE;
    end
    if (cmd_i.accept) begin
      st_rd_q <= state_mem[rd_addr];
    end
  end

  // Payload memory: written by a push, read at the ready head
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      payload_mem[free_head_q] <= push_pl;
    end
    if (cmd_i.accept) begin
      pl_rd_q <= payload_mem[ready_head_q];
    end
  end

  // Latch the operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= operation_i;
      idx_q <= slot_index_i;
      len_q <= length_in_i;
      seq_q <= sequence_in_i;
      ts_q  <= timestamp_in_i;
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      if (pop_ok) begin
        slot_out_q <= ready_wide[dsr_pkg::SlotIdxW-1:0];
        pl_out_q   <= pl_rd_q;
      end else begin
        slot_out_q <= '0;
        pl_out_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= dsr_pkg::MaxPayloadReset;
      running_q     <= 1'b0;
      free_head_q   <= '0;
      ready_head_q  <= '0;
      clr_addr_q    <= '0;
      pkt_push_q    <= '0;
      pkt_pop_q     <= '0;
      byte_push_q   <= '0;
      byte_pop_q    <= '0;
      full_q        <= '0;
      empty_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dsr_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[dsr_pkg::LenW-1:0];
          dsr_pkg::CFG_RUNNING:     running_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.exec) begin
        if (push_ok) begin
          free_head_q <= free_head_q + 1'b1;
          pkt_push_q  <= pkt_push_q + 1'b1;
          byte_push_q <= byte_push_q + dsr_pkg::CntW'(len_q);
        end
        if (pop_ok) begin
          ready_head_q <= ready_head_q + 1'b1;
          pkt_pop_q    <= pkt_pop_q + 1'b1;
          byte_pop_q   <= byte_pop_q + dsr_pkg::CntW'(pl_rd_q.len);
        end
        if (full_hit) begin
          full_q <= full_q + 1'b1;
        end
        if (empty_hit) begin
          empty_q <= empty_q + 1'b1;
        end
      end
    end
  end

  assign status_o         = status_q;
  assign slot_out_o       = slot_out_q;
  assign length_out_o     = pl_out_q.len;
  assign sequence_out_o   = pl_out_q.seq;
  assign timestamp_out_o  = pl_out_q.ts;
  assign packets_pushed_o = pkt_push_q;
  assign packets_popped_o = pkt_pop_q;
  assign bytes_pushed_o   = byte_push_q;
  assign bytes_popped_o   = byte_pop_q;
  assign full_drops_o     = full_q;
  assign empty_pops_o     = empty_q;

endmodule

[rtl/descriptor_slot_ring_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_ring_top
// Ring of packet-descriptor slots (free / ready / in use) with push, pop and
// release operations and wrapping 64-bit traffic counters.
// ----------------------------------------------------------------------------
// Result: start_i is taken at the accept edge (idle to execute state); the
//   execute edge writes back, registers the result and raises done_o.
// Issue: busy_o holds off the next operation until the registered read of
//   the slot state memory has been followed by its write-back; done_o is one
//   cycle wide and the receiver cannot stall it.
// Reset: busy_o stays high after reset while a clearing pass marks every
//   slot free; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module descriptor_slot_ring_top #(
  parameter int SLOT_ORDER = dsr_pkg::RingOrderDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [dsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsr_pkg::CfgDataW-1:0] cfg_data_i,
  // Command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [dsr_pkg::OpW-1:0]      operation_i,
  input  logic [dsr_pkg::SlotIdxW-1:0] slot_index_i,
  input  logic [dsr_pkg::LenW-1:0]     length_in_i,
  input  logic [dsr_pkg::SeqW-1:0]     sequence_in_i,
  input  logic [dsr_pkg::TsW-1:0]      timestamp_in_i,
  // Result
  output logic                         done_o,
  output logic [dsr_pkg::StatW-1:0]    status_o,
  output logic [dsr_pkg::SlotIdxW-1:0] slot_out_o,
  output logic [dsr_pkg::LenW-1:0]     length_out_o,
  output logic [dsr_pkg::SeqW-1:0]     sequence_out_o,
  output logic [dsr_pkg::TsW-1:0]      timestamp_out_o,
  output logic [dsr_pkg::CntW-1:0]     packets_pushed_o,
  output logic [dsr_pkg::CntW-1:0]     packets_popped_o,
  output logic [dsr_pkg::CntW-1:0]     bytes_pushed_o,
  output logic [dsr_pkg::CntW-1:0]     bytes_popped_o,
  output logic [dsr_pkg::CntW-1:0]     full_drops_o,
  output logic [dsr_pkg::CntW-1:0]     empty_pops_o
);

  // Commands down, status up
  dsr_pkg::dsr_cmd_t cmd;
  dsr_pkg::dsr_sts_t sts;

  // Sequence the clearing pass and each transfer: accept, then execute
  dsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Hold slot memories, heads, counters, config and the result registers
  dsr_datapath #(
    .SLOT_ORDER (SLOT_ORDER)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .slot_index_i     (slot_index_i),
    .length_in_i      (length_in_i),
    .sequence_in_i    (sequence_in_i),
    .timestamp_in_i   (timestamp_in_i),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .length_out_o     (length_out_o),
    .sequence_out_o   (sequence_out_o),
    .timestamp_out_o  (timestamp_out_o),
    .packets_pushed_o (packets_pushed_o),
    .packets_popped_o (packets_popped_o),
    .bytes_pushed_o   (bytes_pushed_o),
    .bytes_popped_o   (bytes_popped_o),
    .full_drops_o     (full_drops_o),
    .empty_pops_o     (empty_pops_o)
  );

endmodule

[tb/descriptor_slot_ring_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_ring_checker
// Keeps its own copy of the slot ring and the traffic counters. It predicts
// one result for every accepted command and compares each result strobe,
// field by field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module descriptor_slot_ring_checker
  import dsr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [OpW-1:0]      operation_i,
  input  logic [SlotIdxW-1:0] slot_index_i,
  input  logic [LenW-1:0]     length_in_i,
  input  logic [SeqW-1:0]     sequence_in_i,
  input  logic [TsW-1:0]      timestamp_in_i,
  input  logic                done_i,
  input  logic [StatW-1:0]    status_i,
  input  logic [SlotIdxW-1:0] slot_out_i,
  input  logic [LenW-1:0]     length_out_i,
  input  logic [SeqW-1:0]     sequence_out_i,
  input  logic [TsW-1:0]      timestamp_out_i,
  input  logic [CntW-1:0]     packets_pushed_i,
  input  logic [CntW-1:0]     packets_popped_i,
  input  logic [CntW-1:0]     bytes_pushed_i,
  input  logic [CntW-1:0]     bytes_popped_i,
  input  logic [CntW-1:0]     full_drops_i,
  input  logic [CntW-1:0]     empty_pops_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  localparam int SlotCnt  = 1 << RingOrderDefault;
  localparam int PrintCap = 100;

  typedef struct {
    status_e             status;
    logic [SlotIdxW-1:0] slot;
    logic [LenW-1:0]     len;
    logic [SeqW-1:0]     seq;
    logic [TsW-1:0]      ts;
    logic [CntW-1:0]     push_pkts;
    logic [CntW-1:0]     pop_pkts;
    logic [CntW-1:0]     push_bytes;
    logic [CntW-1:0]     pop_bytes;
    logic [CntW-1:0]     full_drops;
    logic [CntW-1:0]     empty_pops;
  } ring_result_t;

  slot_state_e         slot_st  [SlotCnt];
  logic [LenW-1:0]     slot_len [SlotCnt];
  logic [SeqW-1:0]     slot_seq [SlotCnt];
  logic [TsW-1:0]      slot_ts  [SlotCnt];
  logic [SlotIdxW-1:0] free_head;
  logic [SlotIdxW-1:0] ready_head;
  logic [LenW-1:0]     max_len;
  logic                running;
  logic [CntW-1:0]     cnt_pkts_pushed;
  logic [CntW-1:0]     cnt_pkts_popped;
  logic [CntW-1:0]     cnt_bytes_pushed;
  logic [CntW-1:0]     cnt_bytes_popped;
  logic [CntW-1:0]     cnt_full_drops;
  logic [CntW-1:0]     cnt_empty_pops;
  ring_result_t        due_results_q[$];
  int unsigned         n_fail = 0;

  task automatic report_mismatch(input string msg);
    if (n_fail < PrintCap) $display("[%0t] MISMATCH %s", $time, msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [CntW-1:0] got,
                             input logic [CntW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Apply one command to the mirrored ring and return the result it causes.
  function automatic ring_result_t ring_apply_op(input logic [OpW-1:0] op,
      input logic [SlotIdxW-1:0] idx, input logic [LenW-1:0] len,
      input logic [SeqW-1:0] seq, input logic [TsW-1:0] ts);
    ring_result_t r;
    r.status = STAT_OK;
    r.slot   = '0;
    r.len    = '0;
    r.seq    = '0;
    r.ts     = '0;
    if (!running) begin
      r.status = STAT_STOPPED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (len > max_len) begin
            r.status = STAT_BADARG;
          end else if (slot_st[free_head] != SLOT_FREE) begin
            cnt_full_drops++;
            r.status = STAT_FULL;
          end else if (idx != free_head) begin
            r.status = STAT_BADARG;
          end else begin
            slot_len[free_head] = len;
            slot_seq[free_head] = seq;
            slot_ts[free_head]  = ts;
            slot_st[free_head]  = SLOT_READY;
            free_head           = SlotIdxW'((int'(free_head) + 1) % SlotCnt);
            cnt_pkts_pushed++;
            cnt_bytes_pushed += CntW'(len);
          end
        end
        OP_POP: begin
          if (slot_st[ready_head] != SLOT_READY) begin
            cnt_empty_pops++;
            r.status = STAT_EMPTY;
          end else begin
            r.slot = ready_head;
            r.len  = slot_len[ready_head];
            r.seq  = slot_seq[ready_head];
            r.ts   = slot_ts[ready_head];
            slot_st[ready_head] = SLOT_INUSE;
            ready_head = SlotIdxW'((int'(ready_head) + 1) % SlotCnt);
            cnt_pkts_popped++;
            cnt_bytes_popped += CntW'(r.len);
          end
        end
        OP_RELEASE: begin
          if (int'(idx) >= SlotCnt || slot_st[idx] != SLOT_INUSE) begin
            r.status = STAT_BADARG;
          end else begin
            slot_st[idx]  = SLOT_FREE;
            slot_len[idx] = '0;
          end
        end
        default: r.status = STAT_BADARG;
      endcase
    end
    r.push_pkts  = cnt_pkts_pushed;
    r.pop_pkts   = cnt_pkts_popped;
    r.push_bytes = cnt_bytes_pushed;
    r.pop_bytes  = cnt_bytes_popped;
    r.full_drops = cnt_full_drops;
    r.empty_pops = cnt_empty_pops;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ring_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCnt; i++) begin
        slot_st[i]  = SLOT_FREE;
        slot_len[i] = '0;
        slot_seq[i] = '0;
        slot_ts[i]  = '0;
      end
      free_head        = '0;
      ready_head       = '0;
      max_len          = MaxPayloadReset;
      running          = 1'b0;
      cnt_pkts_pushed  = '0;
      cnt_pkts_popped  = '0;
      cnt_bytes_pushed = '0;
      cnt_bytes_popped = '0;
      cnt_full_drops   = '0;
      cnt_empty_pops   = '0;
      due_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= n_fail;
    end else begin
      if (done_i) begin
        if (due_results_q.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = due_results_q.pop_front();
          check_field("status", CntW'(status_i), CntW'(want.status));
          check_field("slot_out", CntW'(slot_out_i), CntW'(want.slot));
          check_field("length_out", CntW'(length_out_i), CntW'(want.len));
          check_field("sequence_out", CntW'(sequence_out_i), CntW'(want.seq));
          check_field("timestamp_out", CntW'(timestamp_out_i), CntW'(want.ts));
          check_field("packets_pushed", packets_pushed_i, want.push_pkts);
          check_field("packets_popped", packets_popped_i, want.pop_pkts);
          check_field("bytes_pushed", bytes_pushed_i, want.push_bytes);
          check_field("bytes_popped", bytes_popped_i, want.pop_bytes);
          check_field("full_drops", full_drops_i, want.full_drops);
          check_field("empty_pops", empty_pops_i, want.empty_pops);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_PAYLOAD: max_len = cfg_data_i;
          CFG_RUNNING:     running = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        due_results_q.push_back(ring_apply_op(operation_i, slot_index_i, length_in_i,
                                              sequence_in_i, timestamp_in_i));
      pending_o    <= due_results_q.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

[tb/descriptor_slot_ring_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_ring_top_tb
// Drives push, pop and release commands into the descriptor slot ring in
// random bursts: a directed opening over the refusal cases and field
// extremes, then random traffic that fills the ring past full and drains it.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module descriptor_slot_ring_top_tb
  import dsr_pkg::*;
;

  localparam int ClkPeriod = 10;
  // Slot heads wrap with the index width, so the ring size must match it.
  localparam int SlotCnt   = 1 << RingOrderDefault;
  // Operation code that the block does not define; must be refused.
  localparam logic [OpW-1:0] OpUndefined = 2'd3;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                start    = 1'b0;
  logic [OpW-1:0]      op       = '0;
  logic [SlotIdxW-1:0] slot_idx = '0;
  logic [LenW-1:0]     len_in   = '0;
  logic [SeqW-1:0]     seq_in   = '0;
  logic [TsW-1:0]      ts_in    = '0;
  logic                busy;
  logic                done;
  logic [StatW-1:0]    status;
  logic [SlotIdxW-1:0] slot_out;
  logic [LenW-1:0]     len_out;
  logic [SeqW-1:0]     seq_out;
  logic [TsW-1:0]      ts_out;
  logic [CntW-1:0]     push_pkts;
  logic [CntW-1:0]     pop_pkts;
  logic [CntW-1:0]     push_bytes;
  logic [CntW-1:0]     pop_bytes;
  logic [CntW-1:0]     full_drops;
  logic [CntW-1:0]     empty_pops;
  int unsigned         pending;
  int unsigned         fail_count;

  // Stimulus-side view of the ring: just enough to aim pushes at the free
  // head and releases at slots that are really in use.
  slot_state_e         plan_st [SlotCnt];
  logic [SlotIdxW-1:0] plan_free  = '0;
  logic [SlotIdxW-1:0] plan_ready = '0;
  logic [SlotIdxW-1:0] plan_inuse[$];
  logic [LenW-1:0]     plan_max   = MaxPayloadReset;
  logic                plan_run   = 1'b0;
  int unsigned         plan_full  = 0;
  int                  burst_left = 1;

  always #(ClkPeriod / 2) clk = ~clk;

  descriptor_slot_ring_top #(
    .SLOT_ORDER(RingOrderDefault)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .start_i          (start),
    .busy_o           (busy),
    .operation_i      (op),
    .slot_index_i     (slot_idx),
    .length_in_i      (len_in),
    .sequence_in_i    (seq_in),
    .timestamp_in_i   (ts_in),
    .done_o           (done),
    .status_o         (status),
    .slot_out_o       (slot_out),
    .length_out_o     (len_out),
    .sequence_out_o   (seq_out),
    .timestamp_out_o  (ts_out),
    .packets_pushed_o (push_pkts),
    .packets_popped_o (pop_pkts),
    .bytes_pushed_o   (push_bytes),
    .bytes_popped_o   (pop_bytes),
    .full_drops_o     (full_drops),
    .empty_pops_o     (empty_pops)
  );

  descriptor_slot_ring_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .start_i          (start),
    .busy_i           (busy),
    .operation_i      (op),
    .slot_index_i     (slot_idx),
    .length_in_i      (len_in),
    .sequence_in_i    (seq_in),
    .timestamp_in_i   (ts_in),
    .done_i           (done),
    .status_i         (status),
    .slot_out_i       (slot_out),
    .length_out_i     (len_out),
    .sequence_out_i   (seq_out),
    .timestamp_out_i  (ts_out),
    .packets_pushed_i (push_pkts),
    .packets_popped_i (pop_pkts),
    .bytes_pushed_i   (push_bytes),
    .bytes_popped_i   (pop_bytes),
    .full_drops_i     (full_drops),
    .empty_pops_i     (empty_pops),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // Advance the stimulus view by one command, assuming the block is right.
  function automatic void plan_track(input logic [OpW-1:0] o,
      input logic [SlotIdxW-1:0] idx, input logic [LenW-1:0] len);
    int pos;
    pos = -1;
    if (!plan_run) return;
    case (o)
      OP_PUSH: begin
        if (len <= plan_max) begin
          if (plan_st[plan_free] != SLOT_FREE) begin
            plan_full++;
          end else if (idx == plan_free) begin
            plan_st[plan_free] = SLOT_READY;
            plan_free++;
          end
        end
      end
      OP_POP: begin
        if (plan_st[plan_ready] == SLOT_READY) begin
          plan_st[plan_ready] = SLOT_INUSE;
          plan_inuse.push_back(plan_ready);
          plan_ready++;
        end
      end
      OP_RELEASE: begin
        if (plan_st[idx] == SLOT_INUSE) begin
          plan_st[idx] = SLOT_FREE;
          for (int k = 0; k < plan_inuse.size(); k++)
            if (pos < 0 && plan_inuse[k] == idx) pos = k;
          if (pos >= 0) plan_inuse.delete(pos);
        end
      end
      default: ;
    endcase
  endfunction

  // End the current burst at random: drop start for a random gap, then pick
  // the next burst length. Now and then a long burst runs with no gap at all.
  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
  endtask

  // Present one command and hold it until the block takes it. The transfer
  // happens at the edge where start is high and busy is low; busy is read
  // right after the edge, so it is the value the block saw at that edge.
  task automatic issue(input logic [OpW-1:0] o, input logic [SlotIdxW-1:0] idx,
                       input logic [LenW-1:0] len, input logic [SeqW-1:0] sq,
                       input logic [TsW-1:0] tstamp);
    plan_track(o, idx, len);
    start    <= 1'b1;
    op       <= o;
    slot_idx <= idx;
    len_in   <= len;
    seq_in   <= sq;
    ts_in    <= tstamp;
    do @(posedge clk); while (busy);
    pace();
  endtask

  // Random command. Weights are in percent; what is left over is noise:
  // any operation code, the undefined one too, with random fields.
  task automatic issue_random(input int push_w, input int pop_w, input int rel_w);
    int                  pick;
    int                  k;
    logic [OpW-1:0]      o;
    logic [SlotIdxW-1:0] idx;
    logic [LenW-1:0]     len;
    pick = $urandom_range(0, 99);
    idx  = SlotIdxW'($urandom);
    len  = LenW'($urandom);
    if (pick < push_w) begin
      o = OP_PUSH;
      // Mostly aim at the free head; sometimes name a stray slot.
      if ($urandom_range(0, 19) != 0) idx = plan_free;
      case ($urandom_range(0, 9))
        0: len = plan_max;
        1: ;                                   // full-width random length
        2: len = '0;
        3: len = (plan_max == '1) ? plan_max : plan_max + 1'b1;
        default: len = LenW'($urandom_range(0, plan_max));
      endcase
    end else if (pick < push_w + pop_w) begin
      o = OP_POP;
    end else if (pick < push_w + pop_w + rel_w) begin
      o = OP_RELEASE;
      if (plan_inuse.size() != 0 && $urandom_range(0, 9) != 0) begin
        k   = $urandom_range(0, plan_inuse.size() - 1);
        idx = plan_inuse[k];
      end
    end else begin
      o = OpW'($urandom);
    end
    issue(o, idx, len, SeqW'($urandom), TsW'($urandom));
  endtask

  // Drop start and wait until every outstanding result has come back and the
  // block is idle before a register changes.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; the extra edge keeps write-enable pulses apart.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RUNNING) plan_run = data[0];
    else plan_max = data;
  endtask

  initial begin : stimulus
    int guard;
    for (int i = 0; i < SlotCnt; i++) plan_st[i] = SLOT_FREE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stopped after reset: every operation is refused and nothing moves.
    // The first transfer also waits out the clearing pass.
    issue(OP_PUSH, '0, LenW'(16), SeqW'(1), TsW'(1));
    issue(OP_POP, '0, '0, '0, '0);
    issue(OP_RELEASE, '0, '0, '0, '0);
    issue(OpUndefined, '0, '0, '0, '0);
    settle();

    // Smallest payload limit.
    write_reg(CFG_MAX_PAYLOAD, CfgDataW'(64));
    write_reg(CFG_RUNNING, CfgDataW'(1));
    issue(OP_POP, '0, '0, '0, '0);                          // nothing ready
    issue(OP_PUSH, '0, LenW'(65), SeqW'(2), TsW'(2));       // one byte too long
    issue(OP_PUSH, SlotIdxW'(7), LenW'(10), SeqW'(3), TsW'(3));  // not the free head
    issue(OP_PUSH, '0, LenW'(64), '1, '1);                  // exactly at the limit
    issue(OP_PUSH, SlotIdxW'(1), '0, '0, '0);               // empty payload
    issue(OP_POP, '0, '0, '0, '0);
    issue(OP_POP, '0, '0, '0, '0);
    issue(OP_POP, '0, '0, '0, '0);                          // drained again
    issue(OP_RELEASE, '0, '0, '0, '0);
    issue(OP_RELEASE, '0, '0, '0, '0);                      // already free
    issue(OP_RELEASE, '1, '0, '0, '0);                      // never used
    issue(OpUndefined, '1, '1, '1, '1);
    issue(OP_RELEASE, SlotIdxW'(1), '0, '0, '0);
    settle();

    // Largest payload the field range names.
    write_reg(CFG_MAX_PAYLOAD, CfgDataW'(1048576));
    issue(OP_PUSH, SlotIdxW'(2), LenW'(1048577), '0, '0);   // just past the limit
    issue(OP_PUSH, SlotIdxW'(2), LenW'(1048576), SeqW'(16'h5A5A), TsW'(32'hA5A5_5A5A));
    issue(OP_POP, '0, '0, '0, '0);
    issue(OP_RELEASE, SlotIdxW'(2), '0, '0, '0);
    settle();

    // Mixed traffic under a random limit.
    write_reg(CFG_MAX_PAYLOAD, CfgDataW'($urandom_range(64, 1048576)));
    burst_left = 1;
    repeat (40) issue_random(45, 25, 22);
    settle();

    // Fill: well-formed pushes under the widest limit, with the odd pop but
    // no releases, until the free head wraps onto occupied slots and several
    // pushes have been turned away as full.
    write_reg(CFG_MAX_PAYLOAD, '1);
    guard = 0;
    while (plan_full < 8 && guard < 1600) begin
      if ($urandom_range(0, 49) == 0) begin
        issue(OP_POP, '0, '0, '0, '0);
      end else begin
        issue(OP_PUSH, plan_free, LenW'($urandom), SeqW'($urandom), TsW'($urandom));
      end
      guard++;
    end
    settle();

    // Stop with the ring loaded: refusals must leave the state alone.
    write_reg(CFG_RUNNING, CfgDataW'(0));
    repeat (10) issue_random(40, 30, 20);
    settle();

    // Restart under the smallest limit and drain: pops and releases dominate.
    write_reg(CFG_RUNNING, CfgDataW'(1));
    write_reg(CFG_MAX_PAYLOAD, CfgDataW'(64));
    repeat (40) issue_random(20, 40, 35);

    // Wait out the last results and the block's own latency, with a bound.
    start <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #(200000 * ClkPeriod);
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/dsr_pkg.sv
rtl/dsr_ctrl.sv
rtl/dsr_datapath.sv
rtl/descriptor_slot_ring_top.sv
tb/descriptor_slot_ring_checker.sv
tb/descriptor_slot_ring_top_tb.sv
